### design/b32sd_pkg.sv
`default_nettype none

package b32sd_pkg;

  localparam logic [7:0] INVALID_SYMBOL = 8'hff;
  localparam logic [7:0] LETTER_FIRST   = 8'h41;
  localparam logic [7:0] LETTER_LAST    = 8'h5a;
  localparam logic [7:0] DIGIT_FIRST    = 8'h32;
  localparam logic [7:0] DIGIT_LAST     = 8'h37;
  localparam logic [7:0] DIGIT_BASE     = 8'h1a;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } char_word_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       done_res;
    logic       error;
  } result_word_t;

  // Maps an alphabet character to its 5-bit value; anything else gives INVALID_SYMBOL.
  function automatic logic [7:0] symbol_value(input logic [7:0] code);
    logic [7:0] value;
    value = INVALID_SYMBOL;
    if (code inside {[LETTER_FIRST:LETTER_LAST]}) begin
      value = code - LETTER_FIRST;
    end else if (code inside {[DIGIT_FIRST:DIGIT_LAST]}) begin
      value = code - DIGIT_FIRST + DIGIT_BASE;
    end
    return value;
  endfunction

endpackage

`default_nettype wire

### design/base32_stream_decoder.sv
// A character word is held in the input register; a result that it produces is registered
// in the result register. Throughput: one character word per cycle while the result port
// is not stalled; the character table lookup and the bit buffer shift sit between the
// input register and the result register.
// Reset (rst, synchronous, active high) empties both registers, clears the bit
// buffer and group position, and leaves the decoder at the start of a new text.
`default_nettype none

module base32_stream_decoder (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     char_valid,
  output logic                    char_stall,
  input  wire b32sd_pkg::char_word_t char_word,
  output logic                    result_valid,
  input  wire                     result_stall,
  output b32sd_pkg::result_word_t result_word
);

  // Input register.
  logic                  s1_valid;
  b32sd_pkg::char_word_t s1_word;

  // Decoder state.
  logic [6:0] pending_bits;
  logic [2:0] pending_count;
  logic [2:0] group_position;
  logic       discarding;

  logic [6:0] pending_bits_next;
  logic [2:0] pending_count_next;
  logic [2:0] group_position_next;
  logic       discarding_next;

  logic                    produce;
  b32sd_pkg::result_word_t result_next;
  logic                    out_free;
  logic                    s1_fire;

  logic [7:0]  sym;
  logic [11:0] acc;
  logic [3:0]  cnt;
  logic [3:0]  rem;
  logic [11:0] mask;
  logic [7:0]  byte_val;
  logic        have_byte;
  logic [6:0]  bits_after;
  logic [2:0]  gp_after;
  logic        bad;

  always_comb begin
    sym        = b32sd_pkg::symbol_value(s1_word.char_code);
    acc        = {pending_bits, sym[4:0]};
    cnt        = {1'b0, pending_count} + 4'd5;
    have_byte  = cnt[3];
    rem        = have_byte ? cnt - 4'd8 : cnt;
    byte_val   = 8'(acc >> rem);
    mask       = ~(12'hfff << rem);
    bits_after = 7'(acc & mask);
    gp_after   = group_position + 3'd1;
    bad        = (gp_after == 3'd1) || (gp_after == 3'd3) || (gp_after == 3'd6) ||
                 (bits_after != 7'd0);

    pending_bits_next   = pending_bits;
    pending_count_next  = pending_count;
    group_position_next = group_position;
    discarding_next     = discarding;
    produce             = 1'b0;
    result_next         = '0;

    if (discarding) begin
      // The rest of a rejected text is dropped; its last word restarts the decoder.
      if (s1_word.end_of_text) begin
        discarding_next     = 1'b0;
        pending_bits_next   = '0;
        pending_count_next  = '0;
        group_position_next = '0;
      end
    end else if (sym == b32sd_pkg::INVALID_SYMBOL) begin
      pending_bits_next    = '0;
      pending_count_next   = '0;
      group_position_next  = '0;
      discarding_next      = !s1_word.end_of_text;
      produce              = 1'b1;
      result_next.done_res = 1'b1;
      result_next.error    = 1'b1;
    end else if (s1_word.end_of_text) begin
      pending_bits_next      = '0;
      pending_count_next     = '0;
      group_position_next    = '0;
      produce                = 1'b1;
      result_next.data_byte  = have_byte ? byte_val : 8'd0;
      result_next.byte_valid = have_byte;
      result_next.done_res   = 1'b1;
      result_next.error      = bad;
    end else begin
      pending_bits_next      = bits_after;
      pending_count_next     = rem[2:0];
      group_position_next    = gp_after;
      produce                = have_byte;
      result_next.data_byte  = byte_val;
      result_next.byte_valid = have_byte;
    end
  end

  assign out_free   = !result_valid || !result_stall;
  assign s1_fire    = s1_valid && (!produce || out_free);
  assign char_stall = s1_valid && !s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      result_valid   <= 1'b0;
      pending_bits   <= '0;
      pending_count  <= '0;
      group_position <= '0;
      discarding     <= 1'b0;
    end else begin
      if (!char_stall) begin
        s1_valid <= char_valid;
      end
      if (s1_fire) begin
        pending_bits   <= pending_bits_next;
        pending_count  <= pending_count_next;
        group_position <= group_position_next;
        discarding     <= discarding_next;
      end
      if (s1_fire && produce) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!char_stall && char_valid) begin
      s1_word <= char_word;
    end
    if (s1_fire && produce) begin
      result_word <= result_next;
    end
  end

endmodule

`default_nettype wire
